>>> sv/i2c_eeprom_transfer_sequencer_macros.svh
// ----------------------------------------------------------------------------
// I2C EEPROM transfer sequencer - assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef I2C_EEPROM_TRANSFER_SEQUENCER_MACROS_SVH
`define I2C_EEPROM_TRANSFER_SEQUENCER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define EE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define EE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/i2cee_pkg.sv
// ----------------------------------------------------------------------------
// i2cee_pkg
// Types, codes and helpers shared by the I2C EEPROM transfer sequencer.
// ----------------------------------------------------------------------------
package i2cee_pkg;

    typedef logic [7:0] byte_t;
    typedef logic [6:0] dev_t;

    // Input item kinds
    typedef enum logic [1:0] {
        MODE_BEGIN_READ  = 2'd0,
        MODE_BEGIN_WRITE = 2'd1,
        MODE_PAYLOAD     = 2'd2,
        MODE_BUS_RESP    = 2'd3
    } mode_t;

    // Result operations
    typedef enum logic [2:0] {
        OP_START = 3'd0,
        OP_STOP  = 3'd1,
        OP_WRITE = 3'd2,
        OP_READ  = 3'd3,
        OP_RDATA = 3'd4,
        OP_DONE  = 3'd5,
        OP_NEED  = 3'd6
    } op_t;

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_RETRY_LIMIT = 1'b0,
        REG_PAGE_MASK   = 1'b1
    } reg_idx_t;

    // Transfer phase, one-hot
    typedef enum logic [6:0] {
        PH_IDLE    = 7'b0000001,
        PH_POLL    = 7'b0000010,
        PH_ADDR    = 7'b0000100,
        PH_RADDR   = 7'b0001000,
        PH_RDATA   = 7'b0010000,
        PH_PAYLOAD = 7'b0100000,
        PH_WDATA   = 7'b1000000
    } phase_t;

    // One result item
    typedef struct packed {
        op_t   op;
        byte_t byte_value;
        logic  ack_to_send;
        logic  success;
        logic  last;
    } res_t;

    // Result slots reserved per input item; one item causes at most three results
    localparam int MAX_RES = 4;

    localparam byte_t RETRY_LIMIT_RST = 8'd10;
    localparam byte_t PAGE_MASK_RST   = 8'd7;

    function automatic res_t mk_res(op_t op, byte_t b, logic ack, logic ok);
        res_t r;
        r.op          = op;
        r.byte_value  = b;
        r.ack_to_send = ack;
        r.success     = ok;
        r.last        = 1'b0;
        return r;
    endfunction

endpackage

>>> sv/i2cee_if.sv
// ----------------------------------------------------------------------------
// i2cee_if
// Valid/ready channels of the sequencer: request items, result items and
// configuration writes.
// ----------------------------------------------------------------------------

// Request channel: host requests, payload bytes and bus responses
interface i2cee_in_if;
    import i2cee_pkg::*;
    logic  valid;
    logic  ready;
    mode_t mode;
    dev_t  device;
    byte_t address;
    byte_t length;
    byte_t data;
    logic  ack_seen;

    modport source (output valid, mode, device, address, length, data, ack_seen,
                    input ready);
    modport sink (input valid, mode, device, address, length, data, ack_seen,
                  output ready);
endinterface

// Result channel: bus primitives and host notifications
interface i2cee_out_if;
    import i2cee_pkg::*;
    logic  valid;
    logic  ready;
    op_t   op;
    byte_t byte_value;
    logic  ack_to_send;
    logic  success;
    logic  last;

    modport source (output valid, op, byte_value, ack_to_send, success, last,
                    input ready);
    modport sink (input valid, op, byte_value, ack_to_send, success, last,
                  output ready);
endinterface

// Configuration write channel
interface i2cee_cfg_if;
    import i2cee_pkg::*;
    logic     valid;
    logic     ready;
    reg_idx_t index;
    byte_t    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> sv/i2c_eeprom_transfer_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_eeprom_transfer_sequencer
// Turns 24Cxx EEPROM read and page-write requests into I2C bus primitives.
// ----------------------------------------------------------------------------
// The sequencer takes one request item per clock. Each accepted item is
// decoded in the cycle it arrives, the transfer state is updated and its zero
// to three result items are pushed into a result queue of FIFO_DEPTH entries,
// which feeds the result channel one item per clock. Request ready is high
// while the queue has room for a full group of results (at most
// FIFO_DEPTH - 4 entries held), so a request item is taken every cycle as long
// as the result side drains; a run of items that each cause several results is
// paced by the single result port, one result per cycle. Configuration writes
// are taken every cycle and should only happen while no transfer is active.
// FIFO_DEPTH must be a power of two and at least 8.
// ----------------------------------------------------------------------------
module i2c_eeprom_transfer_sequencer #(
    parameter int FIFO_DEPTH = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    i2cee_in_if.sink    req,
    i2cee_out_if.source res,
    i2cee_cfg_if.sink   cfg
);
    import i2cee_pkg::*;

`include "i2c_eeprom_transfer_sequencer_macros.svh"

    localparam int PW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);

    // Configuration registers
    byte_t retry_limit_reg;
    byte_t page_mask_reg;

    // Transfer state
    phase_t phase_reg, phase_next;
    logic   is_write_reg, is_write_next;
    dev_t   device_reg, device_next;
    byte_t  wa_reg, wa_next;
    byte_t  rem_reg, rem_next;
    byte_t  tries_reg, tries_next;

    // Result queue
    res_t          fifo_mem [FIFO_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] cnt_reg, cnt_next;

    // Step outputs
    res_t       res_new [MAX_RES];
    logic [2:0] n_new;

    logic  acc, pop;
    byte_t rem_dec, wa_inc, tries_dec, tries_load, addr_w, addr_r;

    assign cfg.ready = 1'b1;
    assign req.ready = (cnt_reg <= CW'(FIFO_DEPTH - MAX_RES));
    assign acc       = req.valid && req.ready;
    assign pop       = res.valid && res.ready;

    assign rem_dec    = rem_reg - 8'd1;
    assign wa_inc     = wa_reg + 8'd1;
    assign tries_dec  = tries_reg - 8'd1;
    assign tries_load = (retry_limit_reg == 8'd0) ? 8'd1 : retry_limit_reg;
    assign addr_w     = {device_reg, 1'b0};
    assign addr_r     = {device_reg, 1'b1};

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            retry_limit_reg <= RETRY_LIMIT_RST;
            page_mask_reg   <= PAGE_MASK_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_RETRY_LIMIT: retry_limit_reg <= cfg.data;
                REG_PAGE_MASK:   page_mask_reg   <= cfg.data;
                default:         ;
            endcase
        end
    end

    // Per-item step: next state and result group
    always_comb
    begin
        phase_next    = phase_reg;
        is_write_next = is_write_reg;
        device_next   = device_reg;
        wa_next       = wa_reg;
        rem_next      = rem_reg;
        tries_next    = tries_reg;
        n_new         = 3'd0;
        for (int k = 0; k < MAX_RES; k++)
        begin
            res_new[k] = '0;
        end

        case (req.mode)
            MODE_BEGIN_READ, MODE_BEGIN_WRITE:
            begin
                if (phase_reg == PH_IDLE)
                begin
                    is_write_next = (req.mode == MODE_BEGIN_WRITE);
                    device_next   = req.device;
                    wa_next       = req.address;
                    rem_next      = req.length;
                    if (req.mode == MODE_BEGIN_WRITE && req.length == 8'd0)
                    begin
                        res_new[0] = mk_res(OP_DONE, 8'd0, 1'b0, 1'b1);
                        n_new      = 3'd1;
                    end
                    else
                    begin
                        tries_next = tries_load;
                        res_new[0] = mk_res(OP_START, 8'd0, 1'b0, 1'b0);
                        res_new[1] = mk_res(OP_WRITE, {req.device, 1'b0}, 1'b0, 1'b0);
                        n_new      = 3'd2;
                        phase_next = PH_POLL;
                    end
                end
            end
            MODE_PAYLOAD:
            begin
                if (phase_reg == PH_PAYLOAD)
                begin
                    res_new[0] = mk_res(OP_WRITE, req.data, 1'b0, 1'b0);
                    n_new      = 3'd1;
                    phase_next = PH_WDATA;
                end
            end
            default:
            begin
                case (phase_reg)
                    PH_POLL:
                    begin
                        if (req.ack_seen)
                        begin
                            res_new[0] = mk_res(OP_WRITE, wa_reg, 1'b0, 1'b0);
                            n_new      = 3'd1;
                            phase_next = PH_ADDR;
                        end
                        else
                        begin
                            // Retry or give up
                            res_new[0] = mk_res(OP_STOP, 8'd0, 1'b0, 1'b0);
                            tries_next = tries_dec;
                            if (tries_dec == 8'd0)
                            begin
                                res_new[1] = mk_res(OP_DONE, 8'd0, 1'b0, 1'b0);
                                n_new      = 3'd2;
                                phase_next = PH_IDLE;
                            end
                            else
                            begin
                                res_new[1] = mk_res(OP_START, 8'd0, 1'b0, 1'b0);
                                res_new[2] = mk_res(OP_WRITE, addr_w, 1'b0, 1'b0);
                                n_new      = 3'd3;
                            end
                        end
                    end
                    PH_ADDR:
                    begin
                        if (is_write_reg)
                        begin
                            res_new[0] = mk_res(OP_NEED, 8'd0, 1'b0, 1'b0);
                            n_new      = 3'd1;
                            phase_next = PH_PAYLOAD;
                        end
                        else
                        begin
                            // Repeated start with read address
                            res_new[0] = mk_res(OP_START, 8'd0, 1'b0, 1'b0);
                            res_new[1] = mk_res(OP_WRITE, addr_r, 1'b0, 1'b0);
                            n_new      = 3'd2;
                            phase_next = PH_RADDR;
                        end
                    end
                    PH_RADDR:
                    begin
                        if (rem_reg == 8'd0)
                        begin
                            res_new[0] = mk_res(OP_STOP, 8'd0, 1'b0, 1'b0);
                            res_new[1] = mk_res(OP_DONE, 8'd0, 1'b0, 1'b1);
                            n_new      = 3'd2;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            res_new[0] = mk_res(OP_READ, 8'd0, rem_reg > 8'd1, 1'b0);
                            n_new      = 3'd1;
                            phase_next = PH_RDATA;
                        end
                    end
                    PH_RDATA:
                    begin
                        res_new[0] = mk_res(OP_RDATA, req.data, 1'b0, 1'b0);
                        rem_next   = rem_dec;
                        if (rem_dec == 8'd0)
                        begin
                            res_new[1] = mk_res(OP_STOP, 8'd0, 1'b0, 1'b0);
                            res_new[2] = mk_res(OP_DONE, 8'd0, 1'b0, 1'b1);
                            n_new      = 3'd3;
                            phase_next = PH_IDLE;
                        end
                        else
                        begin
                            res_new[1] = mk_res(OP_READ, 8'd0, rem_dec > 8'd1, 1'b0);
                            n_new      = 3'd2;
                        end
                    end
                    PH_WDATA:
                    begin
                        wa_next  = wa_inc;
                        rem_next = rem_dec;
                        if (rem_dec == 8'd0)
                        begin
                            res_new[0] = mk_res(OP_STOP, 8'd0, 1'b0, 1'b0);
                            res_new[1] = mk_res(OP_DONE, 8'd0, 1'b0, 1'b1);
                            n_new      = 3'd2;
                            phase_next = PH_IDLE;
                        end
                        else if ((wa_inc & page_mask_reg) == 8'd0)
                        begin
                            // Page boundary: end burst and poll again
                            tries_next = tries_load;
                            res_new[0] = mk_res(OP_STOP, 8'd0, 1'b0, 1'b0);
                            res_new[1] = mk_res(OP_START, 8'd0, 1'b0, 1'b0);
                            res_new[2] = mk_res(OP_WRITE, addr_w, 1'b0, 1'b0);
                            n_new      = 3'd3;
                            phase_next = PH_POLL;
                        end
                        else
                        begin
                            res_new[0] = mk_res(OP_NEED, 8'd0, 1'b0, 1'b0);
                            n_new      = 3'd1;
                            phase_next = PH_PAYLOAD;
                        end
                    end
                    default: ;
                endcase
            end
        endcase

        // Final result of the group carries last
        if (n_new != 3'd0)
        begin
            res_new[2'(n_new - 3'd1)].last = 1'b1;
        end
    end

    // Transfer state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_IDLE;
            is_write_reg <= 1'b0;
            device_reg   <= '0;
            wa_reg       <= '0;
            rem_reg      <= '0;
            tries_reg    <= '0;
        end
        else if (acc)
        begin
            phase_reg    <= phase_next;
            is_write_reg <= is_write_next;
            device_reg   <= device_next;
            wa_reg       <= wa_next;
            rem_reg      <= rem_next;
            tries_reg    <= tries_next;
        end
    end

    // Result queue storage
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < MAX_RES; k++)
        begin
            if (acc && (3'(k) < n_new))
            begin
                fifo_mem[wr_ptr_reg + PW'(k)] <= res_new[k];
            end
        end
    end

    // Result queue pointers
    assign cnt_next = cnt_reg + (acc ? CW'(n_new) : CW'(0)) - CW'(pop);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (acc)
            begin
                wr_ptr_reg <= wr_ptr_reg + PW'(n_new);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            end
            cnt_reg <= cnt_next;
        end
    end

    // Result channel
    assign res.valid       = (cnt_reg != '0);
    assign res.op          = fifo_mem[rd_ptr_reg].op;
    assign res.byte_value  = fifo_mem[rd_ptr_reg].byte_value;
    assign res.ack_to_send = fifo_mem[rd_ptr_reg].ack_to_send;
    assign res.success     = fifo_mem[rd_ptr_reg].success;
    assign res.last        = fifo_mem[rd_ptr_reg].last;

    // Checks
    `EE_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_reg <= CW'(FIFO_DEPTH), "result queue overflow")
    `EE_ASSERT_NEXT(a_cnt_track, 1'b1, cnt_reg == $past(cnt_next), "queue count mismatch")
    `EE_ASSERT_NEXT(a_poll_giveup,
        acc && req.mode == MODE_BUS_RESP && phase_reg == PH_POLL && !req.ack_seen
            && tries_reg == 8'd1,
        phase_reg == PH_IDLE, "poll limit not honored")
    `EE_ASSERT_NOW(a_done_last, res.valid && res.op == OP_DONE, res.last,
        "done result not last of its group")

endmodule
